>>> rtl/vn_pkg.sv
// Shared types and constants for the vector normalization pipeline.
package vn_pkg;

  // Width of the dimension register.
  localparam int CFG_W = 3;

  // Dimension code that selects 4-D mode; every other code means 3-D.
  localparam logic [CFG_W-1:0] DIM_4D = 3'd4;

  // Dimension code loaded at reset.
  localparam logic [CFG_W-1:0] DIM_3D = 3'd3;

  // Per-stage control that travels with each item.
  typedef struct packed {
    logic valid;
    logic four_d;
  } ctl_t;

endpackage

>>> rtl/vn_sumsq.sv
// Absolute values, squares and sum of squares in three register stages.
module vn_sumsq #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  vn_pkg::ctl_t      in_ctl,
  input  logic [4*W-1:0]    comp,
  output vn_pkg::ctl_t      out_ctl,
  output logic [2*W+1:0]    sum,
  output logic [4*W-1:0]    absv,
  output logic [3:0]        neg
);

  vn_pkg::ctl_t   ctl_a, ctl_b;
  logic [W-1:0]   abs_a [0:3];
  logic [3:0]     neg_a, neg_b;
  logic [W-1:0]   abs_b [0:3];
  logic [2*W-1:0] sq_b  [0:3];
  logic [4*W-1:0] abs_c;

  // Control advances with the pipeline; reset clears the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_b   <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl_a   <= in_ctl;
      ctl_b   <= ctl_a;
      out_ctl <= ctl_b;
    end
  end

  // Stage a: magnitude and sign of each component; w drops out in 3-D mode.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [W-1:0] raw;
    logic         use_lane;
    assign raw      = comp[i*W +: W];
    assign use_lane = (i < 3) || in_ctl.four_d;

    always_ff @(posedge clk) begin
      if (en) begin
        neg_a[i] <= use_lane & raw[W-1];
        abs_a[i] <= !use_lane ? '0 : (raw[W-1] ? (~raw + 1'b1) : raw);
      end
    end

    // Stage b: one square per lane.
    always_ff @(posedge clk) begin
      if (en) begin
        sq_b[i]  <= abs_a[i] * abs_a[i];
        abs_b[i] <= abs_a[i];
      end
    end

    assign absv[i*W +: W] = abs_c[i*W +: W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b <= neg_a;
    end
  end

  // Stage c: sum of the four squares, two bits of headroom.
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= {2'b00, sq_b[0]} + {2'b00, sq_b[1]} + {2'b00, sq_b[2]} + {2'b00, sq_b[3]};
      abs_c <= {abs_b[3], abs_b[2], abs_b[1], abs_b[0]};
      neg   <= neg_b;
    end
  end

endmodule

>>> rtl/vn_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module vn_sqrt #(
  parameter int W = 17,
  parameter int D = 68
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] radicand,
  input  logic [D-1:0]   in_side,
  output logic           out_valid,
  output logic [W-1:0]   root,
  output logic [D-1:0]   out_side
);

  localparam int RW = W + 2;

  logic [W-1:0]   root_s [0:W];
  logic [RW-1:0]  rem_s  [0:W];
  logic [2*W-1:0] rad_s  [0:W];
  logic [D-1:0]   side_s [0:W];
  logic [W:0]     vld_s;

  assign root_s[0] = '0;
  assign rem_s[0]  = '0;
  assign rad_s[0]  = radicand;
  assign side_s[0] = in_side;
  assign vld_s[0]  = in_valid;

  // Each stage brings in the next two radicand bits and settles one root bit.
  for (genvar i = 0; i < W; i++) begin : g_stage
    localparam int P = W - 1 - i;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          fits;

    assign rem_sh = {rem_s[i][RW-3:0], rad_s[i][2*P+1 -: 2]};
    assign trial  = {root_s[i], 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= fits ? (rem_sh - trial) : rem_sh;
        root_s[i+1] <= {root_s[i][W-2:0], fits};
        rad_s[i+1]  <= rad_s[i];
        side_s[i+1] <= side_s[i];
      end
    end
  end

  assign out_valid = vld_s[W];
  assign root      = root_s[W];
  assign out_side  = side_s[W];

endmodule

>>> rtl/vn_div.sv
// Four-lane restoring divider, one quotient bit per register stage.
module vn_div #(
  parameter int W = 17,
  parameter int F = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     divisor,
  input  logic [4*(W-1)-1:0] dividend,
  input  logic [3:0]       in_neg,
  output logic             out_valid,
  output logic [W-1:0]     out_divisor,
  output logic [4*(F+1)-1:0] quot,
  output logic [3:0]       out_neg
);

  // The quotient never exceeds 2^F, so F+1 bits cover it.
  localparam int QW = F + 1;
  localparam int AW = W - 1;
  localparam int RW = W + 1;

  logic [W-1:0] div_s [0:QW];
  logic [3:0]   neg_s [0:QW];
  logic [QW:0]  vld_s;

  assign div_s[0] = divisor;
  assign neg_s[0] = in_neg;
  assign vld_s[0] = in_valid;

  // Valid bits, divisor and signs ride alongside the lanes.
  for (genvar k = 0; k < QW; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_s[k+1] <= div_s[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [AW-1:0] a;
    logic [RW-1:0] rem_s [0:QW];
    logic [QW-1:0] q_s   [0:QW];

    // Dividend is a << F; since a <= divisor, a >> 1 is already below it.
    assign a        = dividend[l*AW +: AW];
    assign rem_s[0] = {2'b00, a[AW-1:1]};
    assign q_s[0]   = '0;

    for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [RW-1:0] rem_sh;
      logic          fits;
      logic          bit_in;

      assign bit_in = (k == 0) ? a[0] : 1'b0;
      assign rem_sh = {rem_s[k][RW-2:0], bit_in};
      assign fits   = rem_sh >= {1'b0, div_s[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1] <= fits ? (rem_sh - {1'b0, div_s[k]}) : rem_sh;
          q_s[k+1]   <= {q_s[k][QW-2:0], fits};
        end
      end
    end

    assign quot[l*QW +: QW] = q_s[QW];
  end

  assign out_valid   = vld_s[QW];
  assign out_divisor = div_s[QW];
  assign out_neg     = neg_s[QW];

endmodule

>>> rtl/vector_normalize.sv
// Top level: length and unit vector of a 3-D or 4-D fixed-point vector.
// Stages in order: sum of squares, square root, divider, and sign and output
// register. Throughput is one item per cycle; a stall at the output freezes
// the whole pipeline. Reset clears all valid bits and sets the dimension
// register to 3-D mode.
module vector_normalize #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  // Input: comp_x, comp_y, comp_z, comp_w from the lowest bit up.
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((4*IN_WIDTH+7)/8)*8-1:0] s_tdata,
  // Output: unit_x, unit_y, unit_z, unit_w, magnitude from the lowest bit up.
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((4*(OUT_FRAC_BITS+2)+IN_WIDTH+1+7)/8)*8-1:0] m_tdata,
  // Output flag: zero_vector.
  output logic [0:0] m_tuser,
  // Dimension register write.
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [vn_pkg::CFG_W-1:0] cfg_data
);

  localparam int MAG_W  = IN_WIDTH + 1;
  localparam int UW     = OUT_FRAC_BITS + 2;
  localparam int QW     = OUT_FRAC_BITS + 1;
  localparam int OUT_DW = 4 * UW + MAG_W;
  localparam int OUT_TW = ((OUT_DW + 7) / 8) * 8;
  localparam int SIDE_W = 4 * IN_WIDTH + 4;

  logic [vn_pkg::CFG_W-1:0] dimension;
  logic                     advance;
  vn_pkg::ctl_t             in_ctl, sum_ctl;
  logic [2*IN_WIDTH+1:0]    sum;
  logic [4*IN_WIDTH-1:0]    absv;
  logic [3:0]               neg;
  logic                     sq_valid;
  logic [MAG_W-1:0]         mag;
  logic [SIDE_W-1:0]        sq_side;
  logic                     dv_valid;
  logic [MAG_W-1:0]         dv_mag;
  logic [4*QW-1:0]          quot;
  logic [3:0]               dv_neg;
  logic [UW-1:0]            unit [0:3];
  logic [MAG_W-1:0]         magnitude;
  logic                     zero_vector;

  // The whole pipeline moves whenever the output register can take an item.
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  // Dimension register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= vn_pkg::DIM_3D;
    end else if (cfg_valid && cfg_ready) begin
      dimension <= cfg_data;
    end
  end

  assign in_ctl.valid  = s_tvalid;
  assign in_ctl.four_d = (dimension == vn_pkg::DIM_4D);

  vn_sumsq #(.W(IN_WIDTH)) u_sumsq (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_ctl  (in_ctl),
    .comp    (s_tdata[4*IN_WIDTH-1:0]),
    .out_ctl (sum_ctl),
    .sum     (sum),
    .absv    (absv),
    .neg     (neg)
  );

  vn_sqrt #(.W(MAG_W), .D(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (sum_ctl.valid),
    .radicand  (sum),
    .in_side   ({neg, absv}),
    .out_valid (sq_valid),
    .root      (mag),
    .out_side  (sq_side)
  );

  vn_div #(.W(MAG_W), .F(OUT_FRAC_BITS)) u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .in_valid    (sq_valid),
    .divisor     (mag),
    .dividend    (sq_side[4*IN_WIDTH-1:0]),
    .in_neg      (sq_side[SIDE_W-1 -: 4]),
    .out_valid   (dv_valid),
    .out_divisor (dv_mag),
    .quot        (quot),
    .out_neg     (dv_neg)
  );

  // Output register: apply signs, force zeros for a zero-length vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= dv_valid;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_out
    logic [UW-1:0] q_ext;
    assign q_ext = {1'b0, quot[l*QW +: QW]};

    always_ff @(posedge clk) begin
      if (advance) begin
        if (dv_mag == '0) begin
          unit[l] <= '0;
        end else begin
          unit[l] <= dv_neg[l] ? (~q_ext + 1'b1) : q_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      magnitude   <= dv_mag;
      zero_vector <= (dv_mag == '0);
    end
  end

  assign m_tdata = {{(OUT_TW-OUT_DW){1'b0}}, magnitude, unit[3], unit[2], unit[1], unit[0]};
  assign m_tuser = zero_vector;

`ifndef SYNTHESIS
  // The zero flag and the length agree.
  a_zero_flag : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (zero_vector == (magnitude == '0)))
    else $error("zero_vector disagrees with magnitude");

  // A zero-length vector carries zero components.
  a_zero_units : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && zero_vector) |->
      (unit[0] == '0 && unit[1] == '0 && unit[2] == '0 && unit[3] == '0))
    else $error("zero vector with nonzero unit component");

  // A held output item holds its length.
  a_hold_mag : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(magnitude) && m_tvalid)
    else $error("stalled output changed");

  // Input is taken exactly when the pipeline advances.
  a_ready : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with pipeline");
`endif

endmodule
